/* hdl/fds_pkg.sv */
// ----------------------------------------------------------------------------
// fds_pkg: shared types and constants of the flanger delay sweep
// Store geometry, sample type, configuration record, register map and
// reset values used across the flanger modules.
// ----------------------------------------------------------------------------
package fds_pkg;

	localparam int STORE_DEPTH = 128;
	localparam int SAMPLE_BITS = 24;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int DLY_W       = ADDR_W + 1;
	localparam int NUM_REGS    = 5;
	localparam int PADDR_W     = $clog2(NUM_REGS * 4);
	localparam int PDATA_W     = 32;
	localparam int GAIN_W      = 9;
	localparam int GAIN_SHIFT  = 8;
	localparam int PROD_W      = SAMPLE_BITS + GAIN_W + 1;
	localparam int SUM_W       = PROD_W - GAIN_SHIFT + 1;

	typedef logic [ADDR_W-1:0]             addr_t;
	typedef logic [DLY_W-1:0]              dly_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [7:0]                    sweep_cnt_t;
	typedef logic [GAIN_W-1:0]             gain_t;

	typedef struct packed {
		logic [7:0] sweep_interval;
		logic [6:0] delay_ceil;
		logic [4:0] delay_floor;
		logic [8:0] wet_mix;
		logic [7:0] feedback_gain;
	} cfg_t;

	typedef enum logic [2:0] {
		REG_SWEEP_INTERVAL = 3'd0,
		REG_DELAY_CEIL     = 3'd1,
		REG_DELAY_FLOOR    = 3'd2,
		REG_WET_MIX        = 3'd3,
		REG_FEEDBACK_GAIN  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic    en;
		addr_t   addr;
		sample_t data;
	} store_wr_t;

	localparam logic [7:0] RST_SWEEP_INTERVAL = 8'd131;
	localparam logic [6:0] RST_DELAY_CEIL     = 7'd57;
	localparam logic [4:0] RST_DELAY_FLOOR    = 5'd4;
	localparam logic [8:0] RST_WET_MIX        = 9'd256;
	localparam logic [7:0] RST_FEEDBACK_GAIN  = 8'd104;

	localparam gain_t      GAIN_ONE     = gain_t'(256);
	localparam dly_t       DELAY_STEP   = dly_t'(2);
	localparam dly_t       DELAY_LO     = dly_t'(2);
	localparam dly_t       DELAY_HI     = dly_t'(STORE_DEPTH - 2);
	localparam addr_t      DELAY_RESET  = addr_t'(20);
	localparam sweep_cnt_t COUNT_RESET  = sweep_cnt_t'(50);

endpackage

/* hdl/fds_if.sv */
// ----------------------------------------------------------------------------
// fds_if: sample stream channels
// Valid/ready channels carrying the incoming and the flanged audio words.
// ----------------------------------------------------------------------------
interface fds_in_if;
	logic             valid;
	logic             ready;
	fds_pkg::sample_t in_sample;

	modport source (output valid, output in_sample, input ready);
	modport sink (input valid, input in_sample, output ready);
endinterface

interface fds_out_if;
	logic             valid;
	logic             ready;
	fds_pkg::sample_t out_sample;

	modport source (output valid, output out_sample, input ready);
	modport sink (input valid, input out_sample, output ready);
endinterface

/* hdl/flanger_delay_sweep_top.sv */
// ----------------------------------------------------------------------------
// flanger_delay_sweep_top: flanger with triangle-swept delay and feedback
// Takes one signed audio word per accepted transfer and returns one flanged
// word. The block sustains one word per clock cycle while the output is not
// stalled: the delay store is a single memory with one read and one write
// each cycle, so that port pair sets the rate. A word is read from the store
// at the edge that accepts it, its gain products are registered after that,
// and the mixed and saturated result then enters the output register; a
// stalled output holds the pipeline back. The store reads as zero after
// reset through per-entry valid flags, so there is no clearing pass and
// words are taken straight out of reset. Register writes are expected only
// while no word is in flight.
// ----------------------------------------------------------------------------
module flanger_delay_sweep_top (
	input  logic                          clk,
	input  logic                          arst_n,
	fds_in_if.sink                        samples,
	fds_out_if.source                     flanged,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fds_pkg::PADDR_W-1:0]   paddr,
	input  logic [fds_pkg::PDATA_W-1:0]   pwdata,
	output logic [fds_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	fds_pkg::cfg_t      cfg;
	fds_pkg::addr_t     rd_addr, wr_pos, cur_delay;
	fds_pkg::store_wr_t wr;
	fds_pkg::sample_t   d;
	logic               accept, ready;

	assign samples.ready = ready;
	assign accept        = samples.valid && ready;

	fds_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fds_sweep u_sweep (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.rd_addr   (rd_addr),
		.wr_pos    (wr_pos),
		.cur_delay (cur_delay)
	);

	fds_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.wr      (wr),
		.rd_data (d)
	);

	fds_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.accept  (accept),
		.x_in    (samples.in_sample),
		.wp_in   (wr_pos),
		.d_in    (d),
		.ready   (ready),
		.wr      (wr),
		.flanged (flanged)
	);

	a_delay_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fds_pkg::dly_t'(cur_delay) >= fds_pkg::DELAY_LO)
		&& (fds_pkg::dly_t'(cur_delay) <= fds_pkg::DELAY_HI))
		else $error("sweep delay outside store range");

	a_wp_advance: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (wr_pos == (($past(wr_pos) == fds_pkg::addr_t'(fds_pkg::STORE_DEPTH - 1))
			? '0 : $past(wr_pos) + 1'b1)))
		else $error("write position did not advance on an accepted word");

	a_write_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> flanged.valid)
		else $error("store write without a word entering the output register");

endmodule

/* hdl/fds_apb_regs.sv */
// ----------------------------------------------------------------------------
// fds_apb_regs: configuration register file
// APB-style write and read access to the sweep and gain registers.
// ----------------------------------------------------------------------------
module fds_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fds_pkg::PADDR_W-1:0]   paddr,
	input  logic [fds_pkg::PDATA_W-1:0]   pwdata,
	output logic [fds_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output fds_pkg::cfg_t                 cfg
);

	fds_pkg::cfg_t     cfg_q;
	fds_pkg::reg_idx_t idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign idx    = fds_pkg::reg_idx_t'(paddr[fds_pkg::PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sweep_interval <= fds_pkg::RST_SWEEP_INTERVAL;
			cfg_q.delay_ceil     <= fds_pkg::RST_DELAY_CEIL;
			cfg_q.delay_floor    <= fds_pkg::RST_DELAY_FLOOR;
			cfg_q.wet_mix        <= fds_pkg::RST_WET_MIX;
			cfg_q.feedback_gain  <= fds_pkg::RST_FEEDBACK_GAIN;
		end else if (wr_en) begin
			unique case (idx)
				fds_pkg::REG_SWEEP_INTERVAL: cfg_q.sweep_interval <= pwdata[7:0];
				fds_pkg::REG_DELAY_CEIL:     cfg_q.delay_ceil     <= pwdata[6:0];
				fds_pkg::REG_DELAY_FLOOR:    cfg_q.delay_floor    <= pwdata[4:0];
				fds_pkg::REG_WET_MIX:        cfg_q.wet_mix        <= pwdata[8:0];
				fds_pkg::REG_FEEDBACK_GAIN:  cfg_q.feedback_gain  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			fds_pkg::REG_SWEEP_INTERVAL: prdata[7:0] = cfg_q.sweep_interval;
			fds_pkg::REG_DELAY_CEIL:     prdata[6:0] = cfg_q.delay_ceil;
			fds_pkg::REG_DELAY_FLOOR:    prdata[4:0] = cfg_q.delay_floor;
			fds_pkg::REG_WET_MIX:        prdata[8:0] = cfg_q.wet_mix;
			fds_pkg::REG_FEEDBACK_GAIN:  prdata[7:0] = cfg_q.feedback_gain;
			default:                     prdata = '0;
		endcase
	end

endmodule

/* hdl/fds_sweep.sv */
// ----------------------------------------------------------------------------
// fds_sweep: triangle sweep and address generation
// Countdown, delay stepping with direction turns, clamping, and the
// circular write and read positions of the delay store.
// ----------------------------------------------------------------------------
module fds_sweep (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fds_pkg::cfg_t         cfg,
	input  logic                  accept,
	output fds_pkg::addr_t        rd_addr,
	output fds_pkg::addr_t        wr_pos,
	output fds_pkg::addr_t        cur_delay
);

	fds_pkg::sweep_cnt_t cnt_q, cnt_nx;
	fds_pkg::addr_t      dly_q, wp_q, wp_nx;
	logic                down_q, down_nx, step;
	fds_pkg::dly_t       dly_ext, dly_mv, dly_raw, dly_cl, rd_sum;

	always_comb begin
		dly_ext = fds_pkg::dly_t'(dly_q);
		step    = (cnt_q <= fds_pkg::sweep_cnt_t'(1));
		dly_mv  = down_q ? dly_ext - fds_pkg::DELAY_STEP : dly_ext + fds_pkg::DELAY_STEP;
		down_nx = down_q;
		dly_raw = dly_ext;
		cnt_nx  = cnt_q - fds_pkg::sweep_cnt_t'(1);
		if (step) begin
			dly_raw = dly_mv;
			cnt_nx  = cfg.sweep_interval;
			if (dly_mv > fds_pkg::dly_t'(cfg.delay_ceil)) down_nx = 1'b1;
			if (dly_mv < fds_pkg::dly_t'(cfg.delay_floor)) down_nx = 1'b0;
		end
		if (dly_raw < fds_pkg::DELAY_LO) begin
			dly_cl = fds_pkg::DELAY_LO;
		end else if (dly_raw > fds_pkg::DELAY_HI) begin
			dly_cl = fds_pkg::DELAY_HI;
		end else begin
			dly_cl = dly_raw;
		end
		// circular read position, wp - delay modulo depth
		rd_sum = fds_pkg::dly_t'(wp_q) + fds_pkg::dly_t'(fds_pkg::STORE_DEPTH) - dly_cl;
		if (rd_sum >= fds_pkg::dly_t'(fds_pkg::STORE_DEPTH)) begin
			rd_addr = fds_pkg::addr_t'(rd_sum - fds_pkg::dly_t'(fds_pkg::STORE_DEPTH));
		end else begin
			rd_addr = fds_pkg::addr_t'(rd_sum);
		end
		wp_nx = (wp_q == fds_pkg::addr_t'(fds_pkg::STORE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= fds_pkg::COUNT_RESET;
			dly_q  <= fds_pkg::DELAY_RESET;
			down_q <= 1'b0;
			wp_q   <= '0;
		end else if (accept) begin
			cnt_q  <= cnt_nx;
			dly_q  <= fds_pkg::addr_t'(dly_cl);
			down_q <= down_nx;
			wp_q   <= wp_nx;
		end
	end

	assign wr_pos    = wp_q;
	assign cur_delay = dly_q;

endmodule

/* hdl/fds_store.sv */
// ----------------------------------------------------------------------------
// fds_store: delay store memory
// Single-write, single-read synchronous memory with per-entry valid flags
// for the cleared state and forwarding of writes landing on a pending read.
// ----------------------------------------------------------------------------
module fds_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  fds_pkg::addr_t       rd_addr,
	input  fds_pkg::store_wr_t   wr,
	output fds_pkg::sample_t     rd_data
);

	fds_pkg::sample_t                    mem [fds_pkg::STORE_DEPTH];
	logic [fds_pkg::STORE_DEPTH-1:0]     vld_q;
	fds_pkg::sample_t                    rdata_q, fwd_data_q;
	fds_pkg::addr_t                      rd_q;
	logic                                rd_vld_q, fwd_hit_q;

	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.addr] <= wr.data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			fwd_hit_q <= 1'b0;
			rd_q      <= '0;
		end else begin
			if (wr.en) vld_q[wr.addr] <= 1'b1;
			if (rd_en) begin
				rd_vld_q  <= vld_q[rd_addr];
				rd_q      <= rd_addr;
				fwd_hit_q <= wr.en && (wr.addr == rd_addr);
			end else if (wr.en && (wr.addr == rd_q)) begin
				fwd_hit_q <= 1'b1;
			end
		end
	end

	// latest write to the pending read address
	always_ff @(posedge clk) begin
		if (wr.en && ((rd_en && (wr.addr == rd_addr)) || (!rd_en && (wr.addr == rd_q)))) begin
			fwd_data_q <= wr.data;
		end
	end

	assign rd_data = fwd_hit_q ? fwd_data_q : (rd_vld_q ? rdata_q : '0);

endmodule

/* hdl/fds_blend.sv */
// ----------------------------------------------------------------------------
// fds_blend: mix and feedback datapath
// Gain products, floor scaling, saturating sums, store write-back and the
// output register with its valid/ready pipeline control.
// ----------------------------------------------------------------------------
module fds_blend (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fds_pkg::cfg_t        cfg,
	input  logic                 accept,
	input  fds_pkg::sample_t     x_in,
	input  fds_pkg::addr_t       wp_in,
	input  fds_pkg::sample_t     d_in,
	output logic                 ready,
	output fds_pkg::store_wr_t   wr,
	fds_out_if.source            flanged
);

	typedef logic signed [fds_pkg::PROD_W-1:0] prod_t;

	function automatic fds_pkg::sample_t sat_sum(prod_t a, prod_t b);
		logic [fds_pkg::SUM_W-1:0]                           s;
		logic [fds_pkg::SUM_W-fds_pkg::SAMPLE_BITS:0]        hi;
		fds_pkg::sample_t                                    r;
		s  = {a[fds_pkg::PROD_W-1], a[fds_pkg::PROD_W-1:fds_pkg::GAIN_SHIFT]}
		   + {b[fds_pkg::PROD_W-1], b[fds_pkg::PROD_W-1:fds_pkg::GAIN_SHIFT]};
		hi = s[fds_pkg::SUM_W-1:fds_pkg::SAMPLE_BITS-1];
		if (hi == '0 || hi == '1) begin
			r = s[fds_pkg::SAMPLE_BITS-1:0];
		end else if (s[fds_pkg::SUM_W-1]) begin
			r = {1'b1, {(fds_pkg::SAMPLE_BITS-1){1'b0}}};
		end else begin
			r = {1'b0, {(fds_pkg::SAMPLE_BITS-1){1'b1}}};
		end
		return r;
	endfunction

	logic             v_s1, v_s2, out_v_q;
	logic             adv_out, adv_s2, adv_s1;
	fds_pkg::sample_t x_s1, out_q, y, st;
	fds_pkg::addr_t   wp_s1, wp_s2;
	fds_pkg::gain_t   m, mc, f, fc;
	prod_t            pdm, pxm, pdf, pxf;
	prod_t            pdm_s2, pxm_s2, pdf_s2, pxf_s2;

	assign adv_out = !out_v_q || flanged.ready;
	assign adv_s2  = !v_s2 || adv_out;
	assign adv_s1  = !v_s1 || adv_s2;
	assign ready   = adv_s1;

	always_comb begin
		m   = (cfg.wet_mix > fds_pkg::GAIN_ONE) ? fds_pkg::GAIN_ONE : cfg.wet_mix;
		mc  = fds_pkg::GAIN_ONE - m;
		f   = fds_pkg::gain_t'(cfg.feedback_gain);
		fc  = fds_pkg::GAIN_ONE - f;
		pdm = d_in * $signed({1'b0, m});
		pxm = x_s1 * $signed({1'b0, mc});
		pdf = d_in * $signed({1'b0, f});
		pxf = x_s1 * $signed({1'b0, fc});
	end

	assign y  = sat_sum(pdm_s2, pxm_s2);
	assign st = sat_sum(pdf_s2, pxf_s2);

	assign wr.en   = v_s2 && adv_out;
	assign wr.addr = wp_s2;
	assign wr.data = st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv_s1)  v_s1    <= accept;
			if (adv_s2)  v_s2    <= v_s1;
			if (adv_out) out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1  <= x_in;
			wp_s1 <= wp_in;
		end
		if (adv_s2 && v_s1) begin
			pdm_s2 <= pdm;
			pxm_s2 <= pxm;
			pdf_s2 <= pdf;
			pxf_s2 <= pxf;
			wp_s2  <= wp_s1;
		end
		if (adv_out && v_s2) out_q <= y;
	end

	assign flanged.valid      = out_v_q;
	assign flanged.out_sample = out_q;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for flanger_delay_sweep_top
// Drives signed sample words through the valid/ready channels and programmes
// the sweep, mix and feedback registers over the register port between
// phases. A scoreboard holds its own model of the delay store and the
// triangle sweep, predicts every flanged word and compares it with the block.
// ----------------------------------------------------------------------------
class flanger_scoreboard;
	typedef logic [fds_pkg::PDATA_W-1:0] word_t;

	fds_pkg::sample_t line_store [fds_pkg::STORE_DEPTH];
	fds_pkg::addr_t   write_pos;
	int               delay_now;
	bit               sweeping_down;
	int               sweep_count;
	logic [7:0]       sweep_interval;
	logic [6:0]       delay_ceil;
	logic [4:0]       delay_floor;
	logic [8:0]       wet_mix;
	logic [7:0]       feedback_gain;
	fds_pkg::sample_t flanged_due [$];
	int               fail_count;
	int               words_in;
	int               words_checked;

	function new();
		foreach (line_store[i])
			line_store[i] = '0;
		write_pos      = '0;
		delay_now      = int'(fds_pkg::DELAY_RESET);
		sweeping_down  = 1'b0;
		sweep_count    = int'(fds_pkg::COUNT_RESET);
		sweep_interval = fds_pkg::RST_SWEEP_INTERVAL;
		delay_ceil     = fds_pkg::RST_DELAY_CEIL;
		delay_floor    = fds_pkg::RST_DELAY_FLOOR;
		wet_mix        = fds_pkg::RST_WET_MIX;
		feedback_gain  = fds_pkg::RST_FEEDBACK_GAIN;
		fail_count     = 0;
		words_in       = 0;
		words_checked  = 0;
	endfunction

	function void apply_reg(fds_pkg::reg_idx_t r, word_t v);
		case (r)
			fds_pkg::REG_SWEEP_INTERVAL: sweep_interval = v[7:0];
			fds_pkg::REG_DELAY_CEIL:     delay_ceil     = v[6:0];
			fds_pkg::REG_DELAY_FLOOR:    delay_floor    = v[4:0];
			fds_pkg::REG_WET_MIX:        wet_mix        = v[8:0];
			fds_pkg::REG_FEEDBACK_GAIN:  feedback_gain  = v[7:0];
			default:                     ;
		endcase
	endfunction

	function word_t reg_value(fds_pkg::reg_idx_t r);
		case (r)
			fds_pkg::REG_SWEEP_INTERVAL: return word_t'(sweep_interval);
			fds_pkg::REG_DELAY_CEIL:     return word_t'(delay_ceil);
			fds_pkg::REG_DELAY_FLOOR:    return word_t'(delay_floor);
			fds_pkg::REG_WET_MIX:        return word_t'(wet_mix);
			fds_pkg::REG_FEEDBACK_GAIN:  return word_t'(feedback_gain);
			default:                     return '0;
		endcase
	endfunction

	// floor(d*g/256) + floor(x*(256-g)/256), saturated to the sample range
	function fds_pkg::sample_t blend_q8(fds_pkg::sample_t d, fds_pkg::sample_t x, int g);
		longint a;
		longint b;
		longint s;
		longint hi;
		hi = (longint'(1) <<< (fds_pkg::SAMPLE_BITS - 1)) - 1;
		a  = (longint'(d) * g) >>> fds_pkg::GAIN_SHIFT;
		b  = (longint'(x) * (256 - g)) >>> fds_pkg::GAIN_SHIFT;
		s  = a + b;
		if (s > hi)
			s = hi;
		if (s < -hi - 1)
			s = -hi - 1;
		return fds_pkg::sample_t'(s);
	endfunction

	function void note_input(fds_pkg::sample_t x);
		fds_pkg::addr_t   rd;
		fds_pkg::sample_t d;
		int               m;
		if (sweep_count <= 1) begin
			delay_now += sweeping_down ? -2 : 2;
			if (delay_now > int'(delay_ceil))
				sweeping_down = 1'b1;
			if (delay_now < int'(delay_floor))
				sweeping_down = 1'b0;
			sweep_count = int'(sweep_interval);
		end else begin
			sweep_count--;
		end
		if (delay_now < 2)
			delay_now = 2;
		if (delay_now > fds_pkg::STORE_DEPTH - 2)
			delay_now = fds_pkg::STORE_DEPTH - 2;
		rd = fds_pkg::addr_t'(int'(write_pos) - delay_now);
		d  = line_store[rd];
		m  = (wet_mix > 9'd256) ? 256 : int'(wet_mix);
		flanged_due.push_back(blend_q8(d, x, m));
		line_store[write_pos] = blend_q8(d, x, int'(feedback_gain));
		write_pos++;
		words_in++;
	endfunction

	function void check_output(fds_pkg::sample_t y);
		fds_pkg::sample_t exp_y;
		if (flanged_due.size() == 0) begin
			$error("unexpected flanged word: out_sample %0d", y);
			fail_count++;
			return;
		end
		exp_y = flanged_due.pop_front();
		words_checked++;
		if (y !== exp_y) begin
			$error("out_sample mismatch: expected %0d, actual %0d", exp_y, y);
			fail_count++;
		end
	endfunction

	function int pending();
		return flanged_due.size();
	endfunction
endclass

module testbench;
	typedef logic [fds_pkg::PADDR_W-1:0] paddr_t;
	typedef logic [fds_pkg::PDATA_W-1:0] pword_t;

	localparam int     LATENCY    = 3;
	localparam int     PHASES     = 12;
	localparam int     PHASE_LEN  = 85;
	localparam int     IDLE_PCT   = 27;
	localparam paddr_t SPARE_ADDR = paddr_t'(fds_pkg::NUM_REGS * 4);

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	paddr_t            paddr;
	pword_t            pwdata;
	pword_t            prdata;
	logic              pready;
	bit                steady;
	flanger_scoreboard sb = new();

	fds_in_if  samples_if ();
	fds_out_if flanged_if ();

	flanger_delay_sweep_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.flanged (flanged_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		flanged_if.ready <= arst_n && (steady || ($urandom_range(99) >= IDLE_PCT));
	end

	// handshakes are judged at the falling edge, where every signal is settled
	always @(negedge clk) begin
		if (arst_n) begin
			if (samples_if.valid && samples_if.ready)
				sb.note_input(samples_if.in_sample);
			if (flanged_if.valid && flanged_if.ready)
				sb.check_output(flanged_if.out_sample);
		end
	end

	function automatic paddr_t reg_addr(fds_pkg::reg_idx_t r);
		return paddr_t'(int'(r) * 4);
	endfunction

	task automatic apb_write(paddr_t a, pword_t v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(paddr_t a, output pword_t v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= a;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		v = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_readback(fds_pkg::reg_idx_t r);
		pword_t got;
		apb_read(reg_addr(r), got);
		if (got !== sb.reg_value(r)) begin
			$error("%s readback mismatch: expected %0d, actual %0d", r.name(),
				sb.reg_value(r), got);
			sb.fail_count++;
		end
	endtask

	task automatic write_reg(fds_pkg::reg_idx_t r, int unsigned v);
		apb_write(reg_addr(r), pword_t'(v));
		sb.apply_reg(r, pword_t'(v));
		check_readback(r);
	endtask

	task automatic program_sweep(int unsigned si, int unsigned mx, int unsigned mn,
			int unsigned wm, int unsigned fg);
		write_reg(fds_pkg::REG_SWEEP_INTERVAL, si);
		write_reg(fds_pkg::REG_DELAY_CEIL, mx);
		write_reg(fds_pkg::REG_DELAY_FLOOR, mn);
		write_reg(fds_pkg::REG_WET_MIX, wm);
		write_reg(fds_pkg::REG_FEEDBACK_GAIN, fg);
	endtask

	// called at a rising edge; returns at the edge where the word was taken
	task automatic push_sample(fds_pkg::sample_t x);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
		end
		samples_if.valid     <= 1'b1;
		samples_if.in_sample <= x;
		@(negedge clk);
		while (!samples_if.ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic settle();
		samples_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (LATENCY + 2)
			@(posedge clk);
	endtask

	function automatic fds_pkg::sample_t random_word();
		case ($urandom_range(9))
			0:       return 24'h7FFFFF;
			1:       return 24'h800000;
			2, 3:    return fds_pkg::sample_t'(int'($urandom_range(2000)) - 1000);
			default: return fds_pkg::sample_t'($urandom());
		endcase
	endfunction

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		fds_pkg::sample_t directed_words [24];
		int unsigned      si;
		int unsigned      mx;
		int unsigned      mn;
		int unsigned      wm;
		int unsigned      fg;
		int               guard;

		directed_words = '{
			24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001, 24'h555555,
			24'hAAAAAA, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h000100,
			24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000,
			24'hFFFFFF, 24'h000001, 24'h0000FF, 24'hFFFF01, 24'h400000, 24'hC00000
		};

		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		samples_if.valid     = 1'b0;
		samples_if.in_sample = '0;
		steady               = 1'b0;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset values, then words straight out of reset
		for (int i = 0; i < fds_pkg::NUM_REGS; i++)
			check_readback(fds_pkg::reg_idx_t'(i));
		for (int i = 0; i < 12; i++)
			push_sample(directed_words[i]);
		settle();
		program_sweep(131, 57, 4, 128, 255);
		for (int i = 12; i < 24; i++)
			push_sample(directed_words[i]);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					si = 0;   mx = 127; mn = 0;  wm = 511; fg = 255;
				end
				1: begin
					si = 1;   mx = 10;  mn = 20; wm = 0;   fg = 0;
				end
				2: begin
					si = 250; mx = 70;  mn = 2;  wm = 256; fg = 179;
				end
				3: begin
					si = 25;  mx = 0;   mn = 31; wm = 77;  fg = 26;
				end
				default: begin
					case ($urandom_range(9))
						0, 1, 2, 3, 4: si = $urandom_range(30);
						5, 6, 7:       si = $urandom_range(250, 25);
						default:       si = $urandom_range(255);
					endcase
					mx = ($urandom_range(9) < 8) ? $urandom_range(70, 10) : $urandom_range(127);
					mn = ($urandom_range(9) < 8) ? $urandom_range(20, 2) : $urandom_range(31);
					wm = ($urandom_range(9) < 7) ? $urandom_range(256, 77) : $urandom_range(511);
					fg = ($urandom_range(9) < 7) ? $urandom_range(179, 26) : $urandom_range(255);
				end
			endcase
			program_sweep(si, mx, mn, wm, fg);
			if (p == 1)
				apb_write(SPARE_ADDR, '1);
			steady = (p == 2);
			for (int i = 0; i < PHASE_LEN; i++)
				push_sample(random_word());
			settle();
			steady = 1'b0;
		end

		guard = 0;
		while (sb.pending() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 8)
			@(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d flanged words never arrived", sb.pending());
			sb.fail_count++;
		end

		$display("run covered %0d sample words over %0d register settings, %0d words checked",
			sb.words_in, PHASES + 2, sb.words_checked);
		$display("settings took in zero sweep interval, crossed bounds and wet mix past full scale");
		if (sb.fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

/* sim.f */
hdl/fds_pkg.sv
hdl/fds_if.sv
hdl/fds_apb_regs.sv
hdl/fds_sweep.sv
hdl/fds_store.sv
hdl/fds_blend.sv
hdl/flanger_delay_sweep_top.sv
tb/testbench.sv
